// ===== hdl/bkv_pkg.sv =====
`default_nettype none

package bkv_pkg;

  // Deepest nesting of maps below the root that the parser accepts.
  localparam logic [7:0] MAX_DEPTH = 8'd15;

  // Type bytes and the close byte of the document format.
  localparam logic [7:0] BYTE_MAP   = 8'h00;
  localparam logic [7:0] BYTE_STR   = 8'h01;
  localparam logic [7:0] BYTE_NUM   = 8'h02;
  localparam logic [7:0] BYTE_CLOSE = 8'h08;

  // Entry kinds as they appear in the type byte.
  localparam logic [1:0] KIND_MAP = 2'd0;
  localparam logic [1:0] KIND_STR = 2'd1;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_KEY,
    PH_STR,
    PH_NUM,
    PH_DONE,
    PH_FAIL_TYPE,
    PH_FAIL_TRUNC,
    PH_FAIL_DEEP
  } phase_t;

  typedef enum logic [3:0] {
    EV_TYPE,
    EV_KEY_BYTE,
    EV_KEY_END,
    EV_STR_BYTE,
    EV_STR_END,
    EV_NUM_BYTE,
    EV_NUM_DONE,
    EV_MAP_CLOSE,
    EV_DOC_DONE,
    EV_ERROR,
    EV_IGNORED
  } event_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_BAD_TYPE,
    ERR_TRUNC,
    ERR_DEEP
  } err_t;

  // One byte of the document as it waits in the input register.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // One parser event.
  typedef struct packed {
    event_t      ev;
    logic [7:0]  payload;
    logic [31:0] number;
    logic [1:0]  kind;
    logic [3:0]  depth;
    err_t        err;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/binary_key_value_stream_parser_core.sv =====
// Binary key-value document parser, one byte per transfer.
// Input channel: in_tdata carries one document byte, in_tlast marks the last
// byte of the buffer. Result channel: one event per input byte; out_tuser is
// the event code and out_tdata carries payload, number, kind, depth and error.
// Path: an accepted byte waits in the input register and is parsed into the result
// register when that register can load (one input register, one result register).
// Throughput is one byte per cycle while a low out_tready does not stall the result;
// the phase, depth and number update is a single short step between the input
// register and the result register.
// Reset: the parser expects the first type byte of the root map, depth is
// zero and both registers are empty. After the root close or any error every
// further byte yields an ignored event until the next reset.
// Stalls: while out_tready is low the result register holds its event, the
// input register still takes one byte, and in_tready drops once both hold
// data. Nothing is dropped or repeated.
`default_nettype none

module binary_key_value_stream_parser_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // end_of_buffer
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [7:0] payload_byte, [39:8] number_value,
                                       // [41:40] entry_kind, [45:42] nesting_depth,
                                       // [47:46] fault_code
  output logic [3:0]       out_tuser   // [3:0] event_res
);

  logic             item_valid;
  bkv_pkg::item_t   item;
  logic             out_adv;
  logic             step;
  bkv_pkg::result_t res;
  bkv_pkg::result_t out_res_r;
  logic             out_valid_r;
  logic             out_valid_nxt;

  // The result register can load when empty or when its event is taken.
  assign out_adv = !out_valid_r || out_tready;
  assign step    = item_valid && out_adv;

  bkv_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .drain      (out_adv),
    .item_valid (item_valid),
    .item       (item)
  );

  bkv_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .res   (res)
  );

  // Result register valid flag.
  always_comb begin
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  // Pack the event onto the result channel.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.ev;
  assign out_tdata  = {out_res_r.err, out_res_r.depth, out_res_r.kind,
                       out_res_r.number, out_res_r.payload};

endmodule

`default_nettype wire

// ===== hdl/bkv_in_stage.sv =====
`default_nettype none

module bkv_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [7:0]    in_tdata,   // [7:0] data_byte
  input  wire logic          in_tlast,   // end_of_buffer
  input  wire logic          drain,
  output logic               item_valid,
  output bkv_pkg::item_t     item
);

  logic           valid_r;
  logic           valid_nxt;
  bkv_pkg::item_t item_r;

  // The register takes a new byte when it is empty or drains this cycle.
  assign in_tready  = !valid_r || drain;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (drain) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.data <= in_tdata;
      item_r.last <= in_tlast;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bkv_parse.sv =====
`default_nettype none

module bkv_parse (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire bkv_pkg::item_t item,
  output bkv_pkg::result_t   res
);

  bkv_pkg::phase_t phase_r;
  bkv_pkg::phase_t phase_nxt;
  logic [3:0]      depth_r;
  logic [3:0]      depth_nxt;
  logic [1:0]      kind_r;
  logic [1:0]      kind_nxt;
  logic [31:0]     acc_r;
  logic [31:0]     acc_nxt;
  logic [1:0]      idx_r;
  logic [1:0]      idx_nxt;

  bkv_pkg::event_t ev_base;
  bkv_pkg::err_t   err_base;
  logic [7:0]      b;
  logic            too_deep;
  logic            trunc;
  logic [31:0]     acc_ins;

  assign b        = item.data;
  assign too_deep = ({4'b0000, depth_r} >= bkv_pkg::MAX_DEPTH) || (depth_r == 4'hF);
  assign acc_ins  = acc_r | ({24'h000000, b} << {idx_r, 3'b000});

  // Classify the byte against the current phase.
  always_comb begin
    ev_base  = bkv_pkg::EV_IGNORED;
    err_base = bkv_pkg::ERR_NONE;
    unique case (phase_r)
      bkv_pkg::PH_TYPE: begin
        if (b == bkv_pkg::BYTE_CLOSE) begin
          ev_base = (depth_r == 4'd0) ? bkv_pkg::EV_DOC_DONE : bkv_pkg::EV_MAP_CLOSE;
        end else if (b > bkv_pkg::BYTE_NUM) begin
          ev_base  = bkv_pkg::EV_ERROR;
          err_base = bkv_pkg::ERR_BAD_TYPE;
        end else if (b == bkv_pkg::BYTE_MAP && too_deep) begin
          ev_base  = bkv_pkg::EV_ERROR;
          err_base = bkv_pkg::ERR_DEEP;
        end else begin
          ev_base = bkv_pkg::EV_TYPE;
        end
      end
      bkv_pkg::PH_KEY: begin
        ev_base = (b != 8'h00) ? bkv_pkg::EV_KEY_BYTE : bkv_pkg::EV_KEY_END;
      end
      bkv_pkg::PH_STR: begin
        ev_base = (b != 8'h00) ? bkv_pkg::EV_STR_BYTE : bkv_pkg::EV_STR_END;
      end
      bkv_pkg::PH_NUM: begin
        ev_base = (idx_r == 2'd3) ? bkv_pkg::EV_NUM_DONE : bkv_pkg::EV_NUM_BYTE;
      end
      default: begin
        ev_base = bkv_pkg::EV_IGNORED;
      end
    endcase
  end

  // A last byte that is not ignored and neither finishes the document nor fails on its own truncates it.
  assign trunc = item.last && (ev_base != bkv_pkg::EV_IGNORED) &&
                 (ev_base != bkv_pkg::EV_ERROR) && (ev_base != bkv_pkg::EV_DOC_DONE);

  // Next state.
  always_comb begin
    phase_nxt = phase_r;
    depth_nxt = depth_r;
    kind_nxt  = kind_r;
    acc_nxt   = acc_r;
    idx_nxt   = idx_r;
    unique case (ev_base)
      bkv_pkg::EV_DOC_DONE: begin
        phase_nxt = bkv_pkg::PH_DONE;
      end
      bkv_pkg::EV_MAP_CLOSE: begin
        depth_nxt = depth_r - 4'd1;
      end
      bkv_pkg::EV_ERROR: begin
        unique case (err_base)
          bkv_pkg::ERR_BAD_TYPE: phase_nxt = bkv_pkg::PH_FAIL_TYPE;
          bkv_pkg::ERR_DEEP:     phase_nxt = bkv_pkg::PH_FAIL_DEEP;
          default:               phase_nxt = bkv_pkg::PH_FAIL_TRUNC;
        endcase
      end
      bkv_pkg::EV_TYPE: begin
        kind_nxt  = b[1:0];
        acc_nxt   = 32'h0;
        idx_nxt   = 2'd0;
        phase_nxt = bkv_pkg::PH_KEY;
      end
      bkv_pkg::EV_KEY_END: begin
        unique case (kind_r)
          bkv_pkg::KIND_MAP: begin
            depth_nxt = depth_r + 4'd1;
            phase_nxt = bkv_pkg::PH_TYPE;
          end
          bkv_pkg::KIND_STR: phase_nxt = bkv_pkg::PH_STR;
          default:           phase_nxt = bkv_pkg::PH_NUM;
        endcase
      end
      bkv_pkg::EV_STR_END: begin
        phase_nxt = bkv_pkg::PH_TYPE;
      end
      bkv_pkg::EV_NUM_BYTE: begin
        acc_nxt = acc_ins;
        idx_nxt = idx_r + 2'd1;
      end
      bkv_pkg::EV_NUM_DONE: begin
        acc_nxt   = acc_ins;
        idx_nxt   = 2'd0;
        phase_nxt = bkv_pkg::PH_TYPE;
      end
      default: begin
      end
    endcase
    if (trunc) begin
      phase_nxt = bkv_pkg::PH_FAIL_TRUNC;
    end
  end

  // Event fields.
  always_comb begin
    res.ev      = ev_base;
    res.payload = 8'h00;
    res.number  = 32'h0;
    res.kind    = 2'd0;
    res.depth   = depth_nxt;
    res.err     = bkv_pkg::ERR_NONE;
    unique case (ev_base)
      bkv_pkg::EV_TYPE: begin
        res.kind = b[1:0];
      end
      bkv_pkg::EV_KEY_BYTE, bkv_pkg::EV_KEY_END, bkv_pkg::EV_STR_BYTE,
      bkv_pkg::EV_STR_END, bkv_pkg::EV_NUM_BYTE: begin
        res.kind    = kind_r;
        res.payload = b;
      end
      bkv_pkg::EV_NUM_DONE: begin
        res.kind    = kind_r;
        res.payload = b;
        res.number  = acc_ins;
      end
      bkv_pkg::EV_ERROR: begin
        res.err = err_base;
      end
      bkv_pkg::EV_IGNORED: begin
        unique case (phase_r)
          bkv_pkg::PH_FAIL_TYPE:  res.err = bkv_pkg::ERR_BAD_TYPE;
          bkv_pkg::PH_FAIL_TRUNC: res.err = bkv_pkg::ERR_TRUNC;
          bkv_pkg::PH_FAIL_DEEP:  res.err = bkv_pkg::ERR_DEEP;
          default:                res.err = bkv_pkg::ERR_NONE;
        endcase
      end
      default: begin
      end
    endcase
    if (trunc) begin
      res.ev      = bkv_pkg::EV_ERROR;
      res.err     = bkv_pkg::ERR_TRUNC;
      res.payload = 8'h00;
      res.number  = 32'h0;
      res.kind    = 2'd0;
    end
  end

  // Parser state advances once per transfer into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bkv_pkg::PH_TYPE;
      depth_r <= 4'd0;
      kind_r  <= 2'd0;
      acc_r   <= 32'h0;
      idx_r   <= 2'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      depth_r <= depth_nxt;
      kind_r  <= kind_nxt;
      acc_r   <= acc_nxt;
      idx_r   <= idx_nxt;
    end
  end

`ifndef SYNTH
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == bkv_pkg::PH_DONE |=> phase_r == bkv_pkg::PH_DONE)
    else $error("finished parser left the done phase");

  a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == bkv_pkg::PH_FAIL_TYPE || phase_r == bkv_pkg::PH_FAIL_TRUNC ||
     phase_r == bkv_pkg::PH_FAIL_DEEP) |=> $stable(phase_r))
    else $error("failed parser changed phase");

  a_idle_keeps_depth: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(depth_r) && $stable(acc_r))
    else $error("parser state moved without a transfer");

  a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.ev == bkv_pkg::EV_ERROR |-> res.err != bkv_pkg::ERR_NONE)
    else $error("error event without an error code");
`endif

endmodule

`default_nettype wire
